// ===== sv/gtj_pkg.sv =====
// ----------------------------------------------------------------------------
// gtj_pkg
// Shared types, constants and the control store of the greedy text justifier.
// ----------------------------------------------------------------------------
package gtj_pkg;

   localparam int MaxLineWidth = 64;
   localparam int MaxLineWords = 32;
   localparam int LenW         = 7;
   localparam int SpaceW       = 6;
   localparam int CountW       = $clog2(MaxLineWords + 1);
   localparam int IdxW         = $clog2(MaxLineWords);
   localparam int PcW          = 4;
   localparam int DivSteps     = LenW;
   localparam int DivCntW      = $clog2(DivSteps);

   typedef logic [PcW-1:0]    pc_type;
   typedef logic [LenW-1:0]   len_type;
   typedef logic [SpaceW-1:0] space_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [IdxW-1:0]   idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT_GAP,
      OP_EMIT_ONE,
      OP_EMIT_JEND,
      OP_EMIT_LEND,
      OP_STORE
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_NO_REQ,
      COND_NO_FLUSH,
      COND_ONE_WORD,
      COND_DIV_MORE,
      COND_MORE_GAPS,
      COND_NO_EOT
   } cond_type;

   localparam pc_type PC_FETCH  = 4'd0;
   localparam pc_type PC_CHECK  = 4'd1;
   localparam pc_type PC_JSETUP = 4'd2;
   localparam pc_type PC_DIV    = 4'd3;
   localparam pc_type PC_JGAP   = 4'd4;
   localparam pc_type PC_JEND   = 4'd5;
   localparam pc_type PC_STORE  = 4'd6;
   localparam pc_type PC_LTEST  = 4'd7;
   localparam pc_type PC_LGAP   = 4'd8;
   localparam pc_type PC_LEND   = 4'd9;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctl_type;

   typedef struct packed {
      logic req_accept;
      logic flush;
      logic one_word;
      logic div_more;
      logic more_gaps;
      logic eot;
      logic stall;
   } status_type;

   function automatic ctl_type gtj_rom(input pc_type pc);
      ctl_type c;
      case (pc)
         PC_FETCH:  c = '{op: OP_LOAD,      cond: COND_NO_REQ,    target: PC_FETCH};
         PC_CHECK:  c = '{op: OP_CHECK,     cond: COND_NO_FLUSH,  target: PC_STORE};
         PC_JSETUP: c = '{op: OP_DIV_INIT,  cond: COND_ONE_WORD,  target: PC_JEND};
         PC_DIV:    c = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE,  target: PC_DIV};
         PC_JGAP:   c = '{op: OP_EMIT_GAP,  cond: COND_MORE_GAPS, target: PC_JGAP};
         PC_JEND:   c = '{op: OP_EMIT_JEND, cond: COND_JUMP,      target: PC_STORE};
         PC_STORE:  c = '{op: OP_STORE,     cond: COND_NO_EOT,    target: PC_FETCH};
         PC_LTEST:  c = '{op: OP_NONE,      cond: COND_ONE_WORD,  target: PC_LEND};
         PC_LGAP:   c = '{op: OP_EMIT_ONE,  cond: COND_MORE_GAPS, target: PC_LGAP};
         PC_LEND:   c = '{op: OP_EMIT_LEND, cond: COND_JUMP,      target: PC_FETCH};
         default:   c = '{op: OP_NONE,      cond: COND_JUMP,      target: PC_FETCH};
      endcase
      return c;
   endfunction

endpackage

// ===== sv/gtj_sequencer.sv =====
// ----------------------------------------------------------------------------
// gtj_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module gtj_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  gtj_pkg::status_type status,
   output gtj_pkg::ctl_type    ctl
);

   gtj_pkg::pc_type pc_ff, pc_in;
   logic            take;

   assign ctl = gtj_pkg::gtj_rom(pc_ff);

   always_comb begin
      case (ctl.cond)
         gtj_pkg::COND_NEXT:      take = 1'b0;
         gtj_pkg::COND_JUMP:      take = 1'b1;
         gtj_pkg::COND_NO_REQ:    take = !status.req_accept;
         gtj_pkg::COND_NO_FLUSH:  take = !status.flush;
         gtj_pkg::COND_ONE_WORD:  take = status.one_word;
         gtj_pkg::COND_DIV_MORE:  take = status.div_more;
         gtj_pkg::COND_MORE_GAPS: take = status.more_gaps;
         gtj_pkg::COND_NO_EOT:    take = !status.eot;
         default:                 take = 1'b1;
      endcase
   end

   always_comb begin
      if (status.stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + gtj_pkg::pc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gtj_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== sv/gtj_datapath.sv =====
// ----------------------------------------------------------------------------
// gtj_datapath
// Line buffer, width register, serial divider and result register.
// ----------------------------------------------------------------------------
module gtj_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gtj_pkg::ctl_type     ctl,
   output gtj_pkg::status_type  status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  gtj_pkg::len_type     csr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   gtj_pkg::len_type    width_ff;
   gtj_pkg::len_type    w_eff;
   gtj_pkg::len_type    len_ff, len_in, raw_len;
   logic                eot_ff;
   gtj_pkg::len_type    line_buf [gtj_pkg::MaxLineWords];
   gtj_pkg::count_type  count_ff, count_in;
   gtj_pkg::len_type    used_ff, used_in;
   gtj_pkg::idx_type    idx_ff, idx_in;
   gtj_pkg::len_type    sq_ff, sq_in;
   gtj_pkg::idx_type    rem_ff, rem_in;
   logic [gtj_pkg::DivCntW-1:0] dcnt_ff, dcnt_in;
   gtj_pkg::idx_type    divisor;
   gtj_pkg::len_type    sum_len, diff, s_val;
   logic [gtj_pkg::IdxW:0] div_tmp;
   logic                div_ge;
   logic [gtj_pkg::LenW:0] fit_len;
   gtj_pkg::len_type    pad;
   gtj_pkg::len_type    rd_len_ff;
   logic                is_emit, out_free, emit_go;
   gtj_pkg::len_type    emit_len;
   gtj_pkg::space_type  emit_space;
   logic                emit_end, emit_last;
   logic                out_valid_ff;
   gtj_pkg::len_type    out_len_ff;
   gtj_pkg::space_type  out_space_ff;
   logic                out_end_ff, out_last_ff;
   logic                accept;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gtj_pkg::len_type'(gtj_pkg::MaxLineWidth);
      end else if (csr_valid) begin
         width_ff <= csr_data;
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = gtj_pkg::len_type'(1);
      end else if (width_ff > gtj_pkg::len_type'(gtj_pkg::MaxLineWidth)) begin
         w_eff = gtj_pkg::len_type'(gtj_pkg::MaxLineWidth);
      end else begin
         w_eff = width_ff;
      end
   end

   // input transfer and clamp
   assign req_tready = (ctl.op == gtj_pkg::OP_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign raw_len    = req_tdata[gtj_pkg::LenW-1:0];

   always_comb begin
      if (raw_len == '0) begin
         len_in = gtj_pkg::len_type'(1);
      end else if (raw_len > w_eff) begin
         len_in = w_eff;
      end else begin
         len_in = raw_len;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff <= len_in;
         eot_ff <= req_tlast;
      end
   end

   // justification arithmetic
   assign divisor = gtj_pkg::idx_type'(count_ff - gtj_pkg::count_type'(1));
   assign sum_len = used_ff - gtj_pkg::len_type'(divisor);
   assign diff    = (w_eff > sum_len) ? (w_eff - sum_len) : '0;
   assign s_val   = (diff < gtj_pkg::len_type'(divisor)) ? gtj_pkg::len_type'(divisor) : diff;
   assign div_tmp = {rem_ff, sq_ff[gtj_pkg::LenW-1]};
   assign div_ge  = (div_tmp >= {1'b0, divisor});
   assign fit_len = {1'b0, used_ff} + 8'd1 + {1'b0, len_ff};
   assign pad     = (w_eff > used_ff) ? (w_eff - used_ff) : '0;

   // result selection
   always_comb begin
      is_emit    = 1'b1;
      emit_len   = rd_len_ff;
      emit_space = '0;
      emit_end   = 1'b0;
      emit_last  = 1'b0;
      case (ctl.op)
         gtj_pkg::OP_EMIT_GAP: begin
            emit_space = gtj_pkg::space_type'(sq_ff + gtj_pkg::len_type'(idx_ff < rem_ff));
         end
         gtj_pkg::OP_EMIT_ONE: begin
            emit_space = gtj_pkg::space_type'(1);
         end
         gtj_pkg::OP_EMIT_JEND: begin
            emit_space = (count_ff == gtj_pkg::count_type'(1)) ?
                         gtj_pkg::space_type'(pad) : '0;
            emit_end   = 1'b1;
            emit_last  = !eot_ff;
         end
         gtj_pkg::OP_EMIT_LEND: begin
            emit_space = gtj_pkg::space_type'(pad);
            emit_end   = 1'b1;
            emit_last  = 1'b1;
         end
         default: begin
            is_emit = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign emit_go  = is_emit && out_free;

   // line state, walk index and divider
   always_comb begin
      count_in = count_ff;
      used_in  = used_ff;
      idx_in   = idx_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      case (ctl.op)
         gtj_pkg::OP_CHECK: begin
            idx_in = '0;
         end
         gtj_pkg::OP_DIV_INIT: begin
            sq_in   = s_val;
            rem_in  = '0;
            dcnt_in = '0;
         end
         gtj_pkg::OP_DIV_STEP: begin
            rem_in  = div_ge ? gtj_pkg::idx_type'(div_tmp - {1'b0, divisor})
                             : gtj_pkg::idx_type'(div_tmp);
            sq_in   = {sq_ff[gtj_pkg::LenW-2:0], div_ge};
            dcnt_in = dcnt_ff + 1'b1;
         end
         gtj_pkg::OP_EMIT_GAP, gtj_pkg::OP_EMIT_ONE: begin
            if (emit_go) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         gtj_pkg::OP_EMIT_JEND, gtj_pkg::OP_EMIT_LEND: begin
            if (emit_go) begin
               count_in = '0;
               used_in  = '0;
            end
         end
         gtj_pkg::OP_STORE: begin
            idx_in   = '0;
            count_in = count_ff + 1'b1;
            used_in  = (count_ff == '0) ? len_ff : gtj_pkg::len_type'(fit_len);
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.op == gtj_pkg::OP_STORE) begin
         line_buf[count_ff[gtj_pkg::IdxW-1:0]] <= len_ff;
      end
      rd_len_ff <= line_buf[idx_in];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         out_len_ff   <= emit_len;
         out_space_ff <= emit_space;
         out_end_ff   <= emit_end;
         out_last_ff  <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_space_ff, out_len_ff};
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = out_last_ff;

   // status to the sequencer
   always_comb begin
      status.req_accept = accept;
      status.flush      = (count_ff != '0) &&
                          ((count_ff >= gtj_pkg::count_type'(gtj_pkg::MaxLineWords)) ||
                           (fit_len > {1'b0, w_eff}));
      status.one_word   = (count_ff == gtj_pkg::count_type'(1));
      status.div_more   = (dcnt_ff != gtj_pkg::DivCntW'(gtj_pkg::DivSteps - 1));
      status.more_gaps  = ({1'b0, idx_ff} + gtj_pkg::count_type'(2)) != count_ff;
      status.eot        = eot_ff;
      status.stall      = is_emit && !out_free;
   end

endmodule

// ===== sv/greedy_text_justifier_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_text_justifier_unit
// Packs word lengths greedily into justified lines of a set width.
// A word that fits passes fetch, check and store.
// A justified line of n > 1 words adds setup, a 7-step serial divide of the spare
// spaces by the gap count, then one result per cycle; a single word skips the divide.
// An end-of-text line adds one result per word; results stall on rsp_tready.
// Synchronous active-high reset empties the line and sets the width to 64.
// ----------------------------------------------------------------------------
module greedy_text_justifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data,    // line_width
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] word_length
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] out_word_length, [12:7] spaces_after
   output logic        rsp_tlast,   // line_end
   output logic        rsp_tuser    // last_of_run
);

   gtj_pkg::ctl_type    ctl;
   gtj_pkg::status_type status;

   gtj_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   gtj_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/gtj_checker.sv =====
// ----------------------------------------------------------------------------
// gtj_checker
// Port-level checks on the greedy text justifier, bound to the top level.
// ----------------------------------------------------------------------------
module gtj_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [6:0]  csr_data,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_run_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("run ended inside a line");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] != 7'd0) && (rsp_tdata[6:0] <= 7'd64))
      else $error("result word length out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("transfer taken while previous word in work");

endmodule

bind greedy_text_justifier_unit gtj_checker u_gtj_checker (.*);
